// ===== rtl/core/wave_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// wave header parser assertion macros
// shared property forms for the checks in the parser's modules
// ----------------------------------------------------------------------------
`ifndef WAVE_HEADER_PARSER_DEFINES_SVH
`define WAVE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define WHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wave header parser: same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define WHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wave header parser: next-cycle check failed");

`endif

// ===== rtl/core/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// shared constants, status codes and controller/datapath structs of the
// wave header parser
// ----------------------------------------------------------------------------
package whp_pkg;

   // chunk and file tags, first file byte in the top lane
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // fmt field layout and format checks
   localparam int FMT_FIELD_BYTES = 16;
   localparam int FIELD_IDX_W     = $clog2(FMT_FIELD_BYTES);
   localparam int PCM_TAG         = 1;
   localparam int PCM_BITS        = 16;
   localparam int BITS_PER_BYTE   = 8;
   localparam int SAMPLE_BYTES    = PCM_BITS / BITS_PER_BYTE;

   // remainder unit: one dividend bit per step
   localparam int REM_STEPS = 32;
   localparam int REM_CNT_W = $clog2(REM_STEPS);

   // result status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NOT_RIFF  = 4'd1;
   localparam logic [3:0] ST_BAD_SIZE  = 4'd2;
   localparam logic [3:0] ST_NOT_WAVE  = 4'd3;
   localparam logic [3:0] ST_FMT_SHORT = 4'd4;
   localparam logic [3:0] ST_FMT_TRUNC = 4'd5;
   localparam logic [3:0] ST_NO_FMT    = 4'd6;
   localparam logic [3:0] ST_NO_DATA   = 4'd7;
   localparam logic [3:0] ST_NOT_PCM   = 4'd8;
   localparam logic [3:0] ST_NOT_16BIT = 4'd9;
   localparam logic [3:0] ST_NO_CHAN   = 4'd10;
   localparam logic [3:0] ST_BAD_ALIGN = 4'd11;
   localparam logic [3:0] ST_UNALIGNED = 4'd12;

   // controller to datapath commands
   typedef struct packed {
      logic                   take;
      logic                   tag_shift;
      logic                   tag_clear;
      logic                   len_clear;
      logic                   len_lane;
      logic                   fmt_write;
      logic                   fmt_set;
      logic                   data_capture;
      logic                   skip_load;
      logic                   skip_from_fmt;
      logic                   skip_dec;
      logic                   emit;
      logic                   emit_final;
      logic [3:0]             emit_code;
      logic                   clear;
      logic [FIELD_IDX_W-1:0] idx;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic tag_riff;
      logic tag_wave;
      logic tag_fmt;
      logic tag_data;
      logic len_short;
      logic len_zero;
      logic fmt_rest_zero;
      logic skip_done;
      logic fmt_seen;
      logic data_seen;
      logic mod_start;
      logic rem_busy;
      logic rem_last;
   } sts_type;

endpackage

// ===== rtl/core/whp_rem.sv =====
// ----------------------------------------------------------------------------
// whp_rem
// restoring remainder unit: data length modulo block alignment, one
// dividend bit per cycle
// ----------------------------------------------------------------------------
module whp_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        last,
   output logic        rem_zero
);

   logic                          busy_ff, busy_in;
   logic [whp_pkg::REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [whp_pkg::REM_STEPS-1:0] dvd_ff, dvd_in;
   logic [15:0]                   div_ff, div_in;
   logic [15:0]                   rem_ff, rem_in;
   logic [16:0]                   trial;
   logic [16:0]                   diff;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, dvd_ff[whp_pkg::REM_STEPS-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[whp_pkg::REM_STEPS-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? diff[15:0] : trial[15:0];
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and remainder registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign last     = busy_ff && (cnt_ff == whp_pkg::REM_CNT_W'(whp_pkg::REM_STEPS - 1));
   assign rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/core/whp_dpath.sv =====
// ----------------------------------------------------------------------------
// whp_dpath
// parser datapath: tag shifter, chunk length, skip counter, captured fmt
// and data fields, byte position, final checks and result register
// ----------------------------------------------------------------------------
module whp_dpath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       file_byte,
   input  whp_pkg::cmd_type cmd,
   output whp_pkg::sts_type sts,
   output logic [3:0]       rsp_status,
   output logic [15:0]      rsp_audio_format,
   output logic [15:0]      rsp_channel_count,
   output logic [31:0]      rsp_sample_rate,
   output logic [15:0]      rsp_frame_bytes,
   output logic [15:0]      rsp_sample_bits,
   output logic [31:0]      rsp_data_offset,
   output logic [31:0]      rsp_data_length
);

   // parse state
   logic [31:0] tag_ff, tag_in, tag_upd;
   logic [31:0] len_ff, len_in, len_upd;
   logic [32:0] skip_ff, skip_in, skip_upd;
   logic        fmt_seen_ff, fmt_seen_in, fmt_seen_upd;
   logic        data_seen_ff, data_seen_in, data_seen_upd;
   logic [15:0] format_ff, format_in, format_upd;
   logic [15:0] channels_ff, channels_in, channels_upd;
   logic [31:0] rate_ff, rate_in, rate_upd;
   logic [15:0] align_ff, align_in, align_upd;
   logic [15:0] bits_ff, bits_in, bits_upd;
   logic [31:0] offset_ff, offset_in, offset_upd;
   logic [31:0] length_ff, length_in, length_upd;
   logic [31:0] pos_ff, pos_in, pos_upd;

   // result register
   logic [3:0]  out_code_ff;
   logic        out_use_rem_ff;
   logic [15:0] out_format_ff;
   logic [15:0] out_channels_ff;
   logic [31:0] out_rate_ff;
   logic [15:0] out_align_ff;
   logic [15:0] out_bits_ff;
   logic [31:0] out_offset_ff;
   logic [31:0] out_length_ff;

   logic [31:0] tag_shifted;
   logic [31:0] len_full;
   logic [32:0] skip_data;
   logic [32:0] skip_fmt;
   logic [15:0] expect_align;
   logic [3:0]  final_code;
   logic        need_mod;
   logic        mod_start;
   logic        rem_busy;
   logic        rem_last;
   logic        rem_zero;

   assign tag_shifted = {tag_ff[23:0], file_byte};
   assign len_full    = {file_byte, len_ff[23:0]};
   assign skip_data   = {1'b0, len_full} + 33'(len_full[0]);
   assign skip_fmt    = {1'b0, len_ff - 32'(whp_pkg::FMT_FIELD_BYTES)} + 33'(len_ff[0]);

   // state after this beat, before an end-of-file clear
   always_comb begin
      tag_upd       = tag_ff;
      len_upd       = len_ff;
      skip_upd      = skip_ff;
      fmt_seen_upd  = fmt_seen_ff;
      data_seen_upd = data_seen_ff;
      format_upd    = format_ff;
      channels_upd  = channels_ff;
      rate_upd      = rate_ff;
      align_upd     = align_ff;
      bits_upd      = bits_ff;
      offset_upd    = offset_ff;
      length_upd    = length_ff;
      pos_upd       = pos_ff;

      if (cmd.take && (pos_ff != '1)) begin
         pos_upd = pos_ff + 32'd1;
      end

      if (cmd.tag_clear) begin
         tag_upd = '0;
      end else if (cmd.tag_shift) begin
         tag_upd = tag_shifted;
      end

      if (cmd.len_clear) begin
         len_upd = '0;
      end else if (cmd.len_lane) begin
         len_upd[{cmd.idx[1:0], 3'b000} +: 8] = file_byte;
      end

      // fmt field bytes, little endian within each field
      if (cmd.fmt_write) begin
         unique case (cmd.idx[3:1])
            3'd0: format_upd[{cmd.idx[0], 3'b000} +: 8] = file_byte;
            3'd1: channels_upd[{cmd.idx[0], 3'b000} +: 8] = file_byte;
            3'd2, 3'd3: rate_upd[{cmd.idx[1:0], 3'b000} +: 8] = file_byte;
            3'd4, 3'd5: ;
            3'd6: align_upd[{cmd.idx[0], 3'b000} +: 8] = file_byte;
            3'd7: bits_upd[{cmd.idx[0], 3'b000} +: 8] = file_byte;
         endcase
      end

      if (cmd.fmt_set) begin
         fmt_seen_upd = 1'b1;
      end

      if (cmd.data_capture) begin
         offset_upd    = pos_upd;
         length_upd    = len_full;
         data_seen_upd = 1'b1;
      end

      // skip counter: chunk body plus pad byte
      if (cmd.skip_load) begin
         skip_upd = cmd.skip_from_fmt ? skip_fmt : skip_data;
      end else if (cmd.skip_dec && (skip_ff != '0)) begin
         skip_upd = skip_ff - 33'd1;
      end
   end

   // end-of-file clear
   always_comb begin
      tag_in       = cmd.clear ? '0 : tag_upd;
      len_in       = cmd.clear ? '0 : len_upd;
      skip_in      = cmd.clear ? '0 : skip_upd;
      fmt_seen_in  = cmd.clear ? 1'b0 : fmt_seen_upd;
      data_seen_in = cmd.clear ? 1'b0 : data_seen_upd;
      format_in    = cmd.clear ? '0 : format_upd;
      channels_in  = cmd.clear ? '0 : channels_upd;
      rate_in      = cmd.clear ? '0 : rate_upd;
      align_in     = cmd.clear ? '0 : align_upd;
      bits_in      = cmd.clear ? '0 : bits_upd;
      offset_in    = cmd.clear ? '0 : offset_upd;
      length_in    = cmd.clear ? '0 : length_upd;
      pos_in       = cmd.clear ? '0 : pos_upd;
   end

   // header checks ahead of the frame alignment remainder
   assign expect_align = 16'(32'(channels_upd) * 32'(whp_pkg::SAMPLE_BYTES));

   always_comb begin
      final_code = whp_pkg::ST_OK;
      need_mod   = 1'b0;
      priority if (!fmt_seen_upd) begin
         final_code = whp_pkg::ST_NO_FMT;
      end else if (!data_seen_upd) begin
         final_code = whp_pkg::ST_NO_DATA;
      end else if (format_upd != 16'(whp_pkg::PCM_TAG)) begin
         final_code = whp_pkg::ST_NOT_PCM;
      end else if (bits_upd != 16'(whp_pkg::PCM_BITS)) begin
         final_code = whp_pkg::ST_NOT_16BIT;
      end else if (channels_upd == '0) begin
         final_code = whp_pkg::ST_NO_CHAN;
      end else if ((align_upd != expect_align) || (align_upd == '0)) begin
         final_code = whp_pkg::ST_BAD_ALIGN;
      end else begin
         need_mod = 1'b1;
      end
   end

   assign mod_start = cmd.emit && cmd.emit_final && need_mod;

   whp_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (length_upd),
      .divisor  (align_upd),
      .busy     (rem_busy),
      .last     (rem_last),
      .rem_zero (rem_zero)
   );

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= '0;
         len_ff       <= '0;
         skip_ff      <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         format_ff    <= '0;
         channels_ff  <= '0;
         rate_ff      <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         offset_ff    <= '0;
         length_ff    <= '0;
         pos_ff       <= '0;
      end else begin
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         skip_ff      <= skip_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         format_ff    <= format_in;
         channels_ff  <= channels_in;
         rate_ff      <= rate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
         pos_ff       <= pos_in;
      end
   end

   // result register, loaded with the fields as this beat leaves them
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_code_ff     <= cmd.emit_final ? final_code : cmd.emit_code;
         out_use_rem_ff  <= mod_start;
         out_format_ff   <= format_upd;
         out_channels_ff <= channels_upd;
         out_rate_ff     <= rate_upd;
         out_align_ff    <= align_upd;
         out_bits_ff     <= bits_upd;
         out_offset_ff   <= offset_upd;
         out_length_ff   <= length_upd;
      end
   end

   // status to the controller
   always_comb begin
      sts               = '0;
      sts.tag_riff      = (tag_shifted == whp_pkg::TAG_RIFF);
      sts.tag_wave      = (tag_shifted == whp_pkg::TAG_WAVE);
      sts.tag_fmt       = (tag_ff == whp_pkg::TAG_FMT);
      sts.tag_data      = (tag_ff == whp_pkg::TAG_DATA);
      sts.len_short     = (len_full < 32'(whp_pkg::FMT_FIELD_BYTES));
      sts.len_zero      = (len_full == '0);
      sts.fmt_rest_zero = (len_ff == 32'(whp_pkg::FMT_FIELD_BYTES));
      sts.skip_done     = (skip_ff <= 33'd1);
      sts.fmt_seen      = fmt_seen_ff;
      sts.data_seen     = data_seen_ff;
      sts.mod_start     = mod_start;
      sts.rem_busy      = rem_busy;
      sts.rem_last      = rem_last;
   end

   assign rsp_status        = out_use_rem_ff ?
                              (rem_zero ? whp_pkg::ST_OK : whp_pkg::ST_UNALIGNED) :
                              out_code_ff;
   assign rsp_audio_format  = out_format_ff;
   assign rsp_channel_count = out_channels_ff;
   assign rsp_sample_rate   = out_rate_ff;
   assign rsp_frame_bytes   = out_align_ff;
   assign rsp_sample_bits   = out_bits_ff;
   assign rsp_data_offset   = out_offset_ff;
   assign rsp_data_length   = out_length_ff;

endmodule

// ===== rtl/core/whp_ctrl.sv =====
// ----------------------------------------------------------------------------
// whp_ctrl
// parser controller: chunk walk state machine, field byte index and
// result handshake
// ----------------------------------------------------------------------------
`include "wave_header_parser_defines.svh"

module whp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_byte,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output whp_pkg::cmd_type cmd,
   input  whp_pkg::sts_type sts
);

   // parse phases
   localparam logic [2:0] PH_RIFF  = 3'd0;
   localparam logic [2:0] PH_RSIZE = 3'd1;
   localparam logic [2:0] PH_WAVE  = 3'd2;
   localparam logic [2:0] PH_ID    = 3'd3;
   localparam logic [2:0] PH_LEN   = 3'd4;
   localparam logic [2:0] PH_FMT   = 3'd5;
   localparam logic [2:0] PH_SKIP  = 3'd6;
   localparam logic [2:0] PH_DONE  = 3'd7;

   localparam logic [whp_pkg::FIELD_IDX_W-1:0] IDX_WORD_LAST = whp_pkg::FIELD_IDX_W'(3);
   localparam logic [whp_pkg::FIELD_IDX_W-1:0] IDX_FMT_LAST  =
      whp_pkg::FIELD_IDX_W'(whp_pkg::FMT_FIELD_BYTES - 1);

   logic [2:0]                      phase_ff, phase_in;
   logic [whp_pkg::FIELD_IDX_W-1:0] idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [whp_pkg::FIELD_IDX_W-1:0] idx_next;
   logic                            acc;

   // take a beat unless the remainder runs or the result waits
   assign req_stall = sts.rem_busy || (rsp_valid_ff && rsp_stall);
   assign acc       = req_valid && !req_stall;
   assign idx_next  = idx_ff + 1'b1;

   // chunk walk
   always_comb begin
      cmd      = '0;
      cmd.idx  = idx_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (acc) begin
         cmd.take = 1'b1;
         unique case (phase_ff)
            PH_RIFF, PH_WAVE, PH_ID: begin
               cmd.tag_shift = 1'b1;
               idx_in        = idx_next;
               if (idx_ff == IDX_WORD_LAST) begin
                  idx_in = '0;
                  if (phase_ff == PH_RIFF) begin
                     if (sts.tag_riff) begin
                        phase_in = PH_RSIZE;
                     end else begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = whp_pkg::ST_NOT_RIFF;
                        phase_in      = PH_DONE;
                     end
                  end else if (phase_ff == PH_WAVE) begin
                     if (sts.tag_wave) begin
                        phase_in = PH_ID;
                     end else begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = whp_pkg::ST_NOT_WAVE;
                        phase_in      = PH_DONE;
                     end
                  end else begin
                     cmd.len_clear = 1'b1;
                     phase_in      = PH_LEN;
                  end
               end
            end
            PH_RSIZE: begin
               idx_in = idx_next;
               if (idx_ff == IDX_WORD_LAST) begin
                  idx_in        = '0;
                  cmd.tag_clear = 1'b1;
                  phase_in      = PH_WAVE;
               end
            end
            PH_LEN: begin
               cmd.len_lane = 1'b1;
               idx_in       = idx_next;
               if (idx_ff == IDX_WORD_LAST) begin
                  idx_in = '0;
                  if (sts.tag_fmt) begin
                     if (sts.len_short) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = whp_pkg::ST_FMT_SHORT;
                        phase_in      = PH_DONE;
                     end else begin
                        phase_in = PH_FMT;
                     end
                  end else if (sts.tag_data && sts.fmt_seen) begin
                     cmd.data_capture = 1'b1;
                     cmd.emit         = 1'b1;
                     cmd.emit_final   = 1'b1;
                     phase_in         = PH_DONE;
                  end else begin
                     // unknown chunk, or data ahead of fmt: skip its body
                     cmd.data_capture = sts.tag_data;
                     cmd.skip_load    = 1'b1;
                     phase_in         = sts.len_zero ? PH_ID : PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               cmd.fmt_write = 1'b1;
               idx_in        = idx_next;
               if (idx_ff == IDX_FMT_LAST) begin
                  idx_in      = '0;
                  cmd.fmt_set = 1'b1;
                  if (sts.data_seen) begin
                     cmd.emit       = 1'b1;
                     cmd.emit_final = 1'b1;
                     phase_in       = PH_DONE;
                  end else begin
                     cmd.skip_load     = 1'b1;
                     cmd.skip_from_fmt = 1'b1;
                     phase_in          = sts.fmt_rest_zero ? PH_ID : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               cmd.skip_dec = 1'b1;
               if (sts.skip_done) begin
                  phase_in = PH_ID;
               end
            end
            default: ;
         endcase

         // final beat: report the phase if nothing was reported, then restart
         if (req_last_byte) begin
            if (phase_in != PH_DONE) begin
               cmd.emit = 1'b1;
               unique case (phase_in)
                  PH_RIFF:  cmd.emit_code = whp_pkg::ST_NOT_RIFF;
                  PH_RSIZE: cmd.emit_code = whp_pkg::ST_BAD_SIZE;
                  PH_WAVE:  cmd.emit_code = whp_pkg::ST_NOT_WAVE;
                  PH_FMT:   cmd.emit_code = whp_pkg::ST_FMT_TRUNC;
                  default:  cmd.emit_final = 1'b1;
               endcase
            end
            cmd.clear = 1'b1;
            phase_in  = PH_RIFF;
            idx_in    = '0;
         end
      end
   end

   // result valid: at once, or when the remainder finishes
   assign rsp_valid_in = (cmd.emit && !sts.mod_start) || sts.rem_last ||
                         (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `WHP_ASSERT_IMP(a_no_take_while_rem, clock, reset, sts.rem_busy, !acc)
   `WHP_ASSERT_IMP(a_emit_has_room, clock, reset, cmd.emit, !rsp_valid_ff || !rsp_stall)
   `WHP_ASSERT_NEXT(a_clear_restarts, clock, reset, cmd.clear, phase_ff == PH_RIFF && idx_ff == '0)
   `WHP_ASSERT_NEXT(a_rem_holds_result, clock, reset, sts.mod_start, sts.rem_busy && !rsp_valid_ff)

endmodule

// ===== rtl/core/wave_header_parser.sv =====
// Takes one file byte per cycle while no result is being finished.
// A result is valid the cycle after the beat that completes it; when the
// frame alignment check runs, the result waits for the remainder unit
// (one dividend bit per cycle) and the input stalls for that time.
// A result still waiting on the output stalls the input only while held.
// Synchronous active-high reset returns the parser to the RIFF tag search.
// ----------------------------------------------------------------------------
// wave_header_parser
// streaming RIFF/WAVE header parser: checks the file tags, walks the chunks,
// captures the fmt fields and the data chunk place, and reports one status
// ----------------------------------------------------------------------------
module wave_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_audio_format,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_frame_bytes,
   output logic [15:0] rsp_sample_bits,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_data_length
);

   whp_pkg::cmd_type cmd;
   whp_pkg::sts_type sts;

   // chunk walk and handshake
   whp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   // fields, counters and result register
   whp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .file_byte         (req_file_byte),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_audio_format  (rsp_audio_format),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_sample_bits   (rsp_sample_bits),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_data_length   (rsp_data_length)
   );

endmodule

// ===== verif/tb_wave_header_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wave_header_parser
// streams whole WAVE files into the parser one byte beat at a time, mirrors
// the chunk walk in a local header model and compares every status beat
// field by field against the oldest predicted header
// ----------------------------------------------------------------------------
module tb_wave_header_parser;

   // field constants at port width
   localparam logic [15:0] PCM_FORMAT = 16'(whp_pkg::PCM_TAG);
   localparam logic [15:0] PCM_WIDTH  = 16'(whp_pkg::PCM_BITS);
   localparam logic [31:0] FMT_BYTES  = 32'(whp_pkg::FMT_FIELD_BYTES);

   // clock, reset and port signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_file_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [15:0] rsp_audio_format;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_frame_bytes;
   logic [15:0] rsp_sample_bits;
   logic [31:0] rsp_data_offset;
   logic [31:0] rsp_data_length;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] frame_bytes;
      logic [15:0] sample_bits;
      logic [31:0] data_offset;
      logic [31:0] data_length;
   } header_result_type;

   typedef enum logic [3:0] {
      SEEK_RIFF, RIFF_SIZE, SEEK_WAVE, CHUNK_ID, CHUNK_LEN, FMT_FIELDS, SKIP_BODY, FINISHED
   } walk_phase_type;

   header_result_type expected_headers[$];
   logic [7:0]        file_image[$];
   int unsigned       mismatch_count = 0;
   bit                in_idle_enable = 1'b1;
   bit                out_stall_enable = 1'b1;
   int unsigned       stall_left = 0;

   // header model state
   walk_phase_type walk_phase;
   int unsigned field_idx;
   logic [31:0] id_shift;
   logic [31:0] chunk_len;
   logic [32:0] skip_left;
   bit          fmt_known;
   bit          data_known;
   bit          reported;
   logic [15:0] fmt_format;
   logic [15:0] fmt_channels;
   logic [31:0] fmt_rate;
   logic [15:0] fmt_align;
   logic [15:0] fmt_bits;
   logic [31:0] data_at;
   logic [31:0] data_len;
   logic [31:0] position;

   wave_header_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_file_byte     (req_file_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_audio_format  (rsp_audio_format),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_sample_bits   (rsp_sample_bits),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_data_length   (rsp_data_length)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // header model
   // ---------------------------------------------------------------------

   function automatic void clear_parse_state();
      walk_phase   = SEEK_RIFF;
      field_idx    = 0;
      id_shift     = '0;
      chunk_len    = '0;
      skip_left    = '0;
      fmt_known    = 1'b0;
      data_known   = 1'b0;
      reported     = 1'b0;
      fmt_format   = '0;
      fmt_channels = '0;
      fmt_rate     = '0;
      fmt_align    = '0;
      fmt_bits     = '0;
      data_at      = '0;
      data_len     = '0;
      position     = '0;
   endfunction

   // format checks, after the checks that both chunks are known
   function automatic logic [3:0] format_verdict();
      logic [15:0] want_align;
      if (!fmt_known) return whp_pkg::ST_NO_FMT;
      if (!data_known) return whp_pkg::ST_NO_DATA;
      if (fmt_format != PCM_FORMAT) return whp_pkg::ST_NOT_PCM;
      if (fmt_bits != PCM_WIDTH) return whp_pkg::ST_NOT_16BIT;
      if (fmt_channels == 16'd0) return whp_pkg::ST_NO_CHAN;
      want_align = 16'(32'(fmt_channels) * (32'(fmt_bits) / 32'(whp_pkg::BITS_PER_BYTE)));
      if (fmt_align != want_align || fmt_align == 16'd0) return whp_pkg::ST_BAD_ALIGN;
      if (data_len % {16'd0, fmt_align} != 32'd0) return whp_pkg::ST_UNALIGNED;
      return whp_pkg::ST_OK;
   endfunction

   function automatic void record_header(input logic [3:0] status);
      expected_headers.push_back('{status, fmt_format, fmt_channels, fmt_rate,
                                   fmt_align, fmt_bits, data_at, data_len});
      reported   = 1'b1;
      walk_phase = FINISHED;
   endfunction

   function automatic void begin_skip(input logic [32:0] count);
      if (count == 33'd0) begin
         walk_phase = CHUNK_ID;
      end else begin
         skip_left  = count;
         walk_phase = SKIP_BODY;
      end
   endfunction

   function automatic void predict_header_byte(input logic [7:0] value, input logic is_last);
      int unsigned k;
      if (position != 32'hFFFF_FFFF) position++;
      case (walk_phase)
         // four-byte tags: file tags and chunk ids
         SEEK_RIFF, SEEK_WAVE, CHUNK_ID: begin
            id_shift = {id_shift[23:0], value};
            field_idx++;
            if (field_idx >= 4) begin
               field_idx = 0;
               if (walk_phase == SEEK_RIFF) begin
                  if (id_shift != whp_pkg::TAG_RIFF) record_header(whp_pkg::ST_NOT_RIFF);
                  else walk_phase = RIFF_SIZE;
               end else if (walk_phase == SEEK_WAVE) begin
                  if (id_shift != whp_pkg::TAG_WAVE) record_header(whp_pkg::ST_NOT_WAVE);
                  else walk_phase = CHUNK_ID;
               end else begin
                  chunk_len  = '0;
                  walk_phase = CHUNK_LEN;
               end
            end
         end
         // riff size is passed over
         RIFF_SIZE: begin
            field_idx++;
            if (field_idx >= 4) begin
               field_idx  = 0;
               id_shift   = '0;
               walk_phase = SEEK_WAVE;
            end
         end
         // little-endian chunk size, then dispatch on the chunk id
         CHUNK_LEN: begin
            chunk_len[8*field_idx +: 8] = value;
            field_idx++;
            if (field_idx >= 4) begin
               field_idx = 0;
               if (id_shift == whp_pkg::TAG_FMT) begin
                  if (chunk_len < FMT_BYTES) record_header(whp_pkg::ST_FMT_SHORT);
                  else walk_phase = FMT_FIELDS;
               end else if (id_shift == whp_pkg::TAG_DATA) begin
                  data_at    = position;
                  data_len   = chunk_len;
                  data_known = 1'b1;
                  if (fmt_known) record_header(format_verdict());
                  else begin_skip({1'b0, chunk_len} + 33'(chunk_len[0]));
               end else begin
                  begin_skip({1'b0, chunk_len} + 33'(chunk_len[0]));
               end
            end
         end
         // fmt fields, byte rate dropped
         FMT_FIELDS: begin
            k = field_idx;
            if (k < 2) fmt_format[8*k +: 8] = value;
            else if (k < 4) fmt_channels[8*(k-2) +: 8] = value;
            else if (k < 8) fmt_rate[8*(k-4) +: 8] = value;
            else if (k >= 12 && k < 14) fmt_align[8*(k-12) +: 8] = value;
            else if (k >= 14) fmt_bits[8*(k-14) +: 8] = value;
            field_idx++;
            if (field_idx >= whp_pkg::FMT_FIELD_BYTES) begin
               field_idx = 0;
               fmt_known = 1'b1;
               if (data_known) record_header(format_verdict());
               else begin_skip({1'b0, chunk_len - FMT_BYTES} + 33'(chunk_len[0]));
            end
         end
         SKIP_BODY: begin
            if (skip_left != 33'd0) skip_left--;
            if (skip_left == 33'd0) walk_phase = CHUNK_ID;
         end
         default: ;
      endcase

      // end of file: status from where the walk stopped
      if (is_last) begin
         if (!reported) begin
            case (walk_phase)
               SEEK_RIFF:  record_header(whp_pkg::ST_NOT_RIFF);
               RIFF_SIZE:  record_header(whp_pkg::ST_BAD_SIZE);
               SEEK_WAVE:  record_header(whp_pkg::ST_NOT_WAVE);
               FMT_FIELDS: record_header(whp_pkg::ST_FMT_TRUNC);
               default:    record_header(format_verdict());
            endcase
         end
         clear_parse_state();
      end
   endfunction

   // ---------------------------------------------------------------------
   // file image builders
   // ---------------------------------------------------------------------

   function automatic void put_tag(input logic [31:0] tag);
      for (int i = 3; i >= 0; i--) file_image.push_back(tag[8*i +: 8]);
   endfunction

   function automatic void put_le(input logic [31:0] value, input int unsigned count);
      for (int i = 0; i < count; i++) file_image.push_back(value[8*i +: 8]);
   endfunction

   function automatic void put_fill(input int unsigned count);
      repeat (count) file_image.push_back(8'($urandom));
   endfunction

   function automatic void start_file(input logic [31:0] riff_size);
      file_image.delete();
      put_tag(whp_pkg::TAG_RIFF);
      put_le(riff_size, 4);
      put_tag(whp_pkg::TAG_WAVE);
   endfunction

   // chunk with random body and pad byte when odd
   function automatic void put_chunk(input logic [31:0] id, input logic [31:0] len);
      put_tag(id);
      put_le(len, 4);
      put_fill(len + 32'(len[0]));
   endfunction

   function automatic void put_fmt(input logic [31:0] len, input logic [15:0] format,
                                   input logic [15:0] channels, input logic [31:0] rate,
                                   input logic [15:0] align, input logic [15:0] bits);
      put_tag(whp_pkg::TAG_FMT);
      put_le(len, 4);
      put_le(32'(format), 2);
      put_le(32'(channels), 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le(32'(align), 2);
      put_le(32'(bits), 2);
      put_fill(len - FMT_BYTES + 32'(len[0]));
   endfunction

   // file with random content and order, at times with bad fields or cut short
   function automatic void build_random_wave();
      logic [15:0] channels;
      logic [15:0] bits;
      logic [15:0] format;
      logic [15:0] align;
      logic [31:0] size;
      int unsigned cut;
      bit          data_first;
      start_file($urandom);
      data_first = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 9));
      if (data_first) put_chunk(whp_pkg::TAG_DATA, $urandom_range(0, 7));
      channels = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
      if ($urandom_range(0, 15) == 0) channels = 16'($urandom);
      bits   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_WIDTH;
      format = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_FORMAT;
      align  = 16'(32'(channels) * 32'(whp_pkg::SAMPLE_BYTES));
      if ($urandom_range(0, 7) == 0) align = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
      size = 32'(align) * $urandom_range(0, 4096);
      if ($urandom_range(0, 5) == 0) size = $urandom;
      // an earlier fmt that the later one overwrites
      if (!data_first && $urandom_range(0, 5) == 0)
         put_fmt(FMT_BYTES, 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                 16'($urandom));
      put_fmt(FMT_BYTES + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 32'd0),
              format, channels, $urandom, align, bits);
      if (!data_first) begin
         if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 9));
         put_tag(whp_pkg::TAG_DATA);
         put_le(size, 4);
      end
      put_fill($urandom_range(0, 6));
      // early end of file somewhere in the walk
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, file_image.size());
         while (file_image.size() > cut) void'(file_image.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------
   // beat driving
   // ---------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      if (in_idle_enable && $urandom_range(0, 11) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_file_byte = value;
      req_last_byte = is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_header_byte(value, is_last);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_image.size(); i++)
         send_byte(file_image[i], i == file_image.size() - 1);
   endtask

   task automatic send_wave(input logic [15:0] format, input logic [15:0] channels,
                            input logic [31:0] rate, input logic [15:0] align,
                            input logic [15:0] bits, input logic [31:0] size);
      start_file($urandom);
      put_fmt(FMT_BYTES, format, channels, rate, align, bits);
      put_tag(whp_pkg::TAG_DATA);
      put_le(size, 4);
      send_file();
   endtask

   // result stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (out_stall_enable && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 15);
      rsp_stall = (stall_left > 0);
   end

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      header_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_headers.size() == 0) begin
            if (mismatch_count < 10)
               $display("result beat with none expected, status %0d", rsp_status);
            mismatch_count++;
         end else begin
            want = expected_headers.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("audio_format", 32'(want.audio_format), 32'(rsp_audio_format));
            check_field("channel_count", 32'(want.channel_count), 32'(rsp_channel_count));
            check_field("sample_rate", want.sample_rate, rsp_sample_rate);
            check_field("frame_bytes", 32'(want.frame_bytes), 32'(rsp_frame_bytes));
            check_field("sample_bits", 32'(want.sample_bits), 32'(rsp_sample_bits));
            check_field("data_offset", want.data_offset, rsp_data_offset);
            check_field("data_length", want.data_length, rsp_data_length);
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // wrong and cut file tags
   task automatic test_file_tags();
      file_image.delete();
      put_tag(32'h5249_4658);
      put_fill(4);
      send_file();
      file_image.delete();
      put_tag(whp_pkg::TAG_RIFF);
      put_le($urandom, 4);
      put_tag(32'h5741_5658);
      put_fill(2);
      send_file();
      file_image.delete();
      file_image.push_back(8'hFF);
      send_file();
      file_image.delete();
      put_tag(whp_pkg::TAG_RIFF);
      put_fill(2);
      send_file();
      file_image.delete();
      put_tag(whp_pkg::TAG_RIFF);
      put_le(32'hFFFF_FFFF, 4);
      file_image.push_back(8'h57);
      file_image.push_back(8'h41);
      send_file();
      // header only, nothing after the wave tag
      start_file(32'd0);
      send_file();
   endtask

   // short, truncated and oversized fmt chunks
   task automatic test_fmt_errors();
      start_file($urandom);
      put_tag(whp_pkg::TAG_FMT);
      put_le(32'd0, 4);
      put_fill(3);
      send_file();
      start_file($urandom);
      put_tag(whp_pkg::TAG_FMT);
      put_le(32'd15, 4);
      put_fill(15);
      send_file();
      start_file($urandom);
      put_tag(whp_pkg::TAG_FMT);
      put_le(32'd16, 4);
      put_fill(7);
      send_file();
      // largest size: fields taken, then the file ends inside the skip
      start_file($urandom);
      put_tag(whp_pkg::TAG_FMT);
      put_le(32'hFFFF_FFFF, 4);
      put_fill(whp_pkg::FMT_FIELD_BYTES + 6);
      send_file();
      // file ends right after a chunk id
      start_file($urandom);
      put_tag(whp_pkg::TAG_FMT);
      send_file();
   endtask

   // every format verdict with extreme field values
   task automatic test_format_checks();
      send_wave(PCM_FORMAT, 16'd2, 32'd44100, 16'd4, PCM_WIDTH, 32'd64);
      send_wave(16'd3, 16'd2, 32'd48000, 16'd8, 16'd32, 32'd64);
      send_wave(PCM_FORMAT, 16'd1, 32'd8000, 16'd1, 16'd8, 32'd8);
      send_wave(PCM_FORMAT, 16'd0, 32'd8000, 16'd2, PCM_WIDTH, 32'd8);
      send_wave(PCM_FORMAT, 16'd2, 32'd8000, 16'd6, PCM_WIDTH, 32'd12);
      // zero alignment matching the wrapped product
      send_wave(PCM_FORMAT, 16'h8000, 32'd8000, 16'd0, PCM_WIDTH, 32'd0);
      send_wave(PCM_FORMAT, 16'd2, 32'd8000, 16'd4, PCM_WIDTH, 32'd15);
      send_wave(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_wave(PCM_FORMAT, 16'h7FFF, 32'd0, 16'hFFFE, PCM_WIDTH, 32'hFFFF_FFFE);
      send_wave(16'd0, 16'd1, 32'd0, 16'd2, PCM_WIDTH, 32'd0);
   endtask

   // chunk order, pad bytes, repeats and missing chunks
   task automatic test_chunk_walk();
      start_file($urandom);
      put_chunk(32'h4C49_5354, 32'd3);
      put_chunk($urandom, 32'd0);
      put_fmt(32'd19, PCM_FORMAT, 16'd1, 32'd22050, 16'd2, PCM_WIDTH);
      put_tag(whp_pkg::TAG_DATA);
      put_le(32'd10, 4);
      put_fill(3);
      send_file();
      // data payload skipped before fmt arrives
      start_file($urandom);
      put_chunk(whp_pkg::TAG_DATA, 32'd5);
      put_fmt(32'd16, PCM_FORMAT, 16'd2, 32'd96000, 16'd4, PCM_WIDTH);
      put_fill(2);
      send_file();
      // second fmt overwrites the first
      start_file($urandom);
      put_fmt(32'd18, 16'd3, 16'd6, 32'd1, 16'd24, 16'd32);
      put_fmt(32'd16, PCM_FORMAT, 16'd2, 32'd44100, 16'd4, PCM_WIDTH);
      put_tag(whp_pkg::TAG_DATA);
      put_le(32'd400, 4);
      send_file();
      // second data chunk overwrites the first
      start_file($urandom);
      put_chunk(whp_pkg::TAG_DATA, 32'd1);
      put_chunk(whp_pkg::TAG_DATA, 32'd4);
      put_fmt(32'd16, PCM_FORMAT, 16'd1, 32'd8000, 16'd2, PCM_WIDTH);
      send_file();
      // no fmt: file ends inside a large data skip
      start_file($urandom);
      put_chunk($urandom, 32'd2);
      put_tag(whp_pkg::TAG_DATA);
      put_le(32'hFFFF_FFF0, 4);
      put_fill(5);
      send_file();
      // no data
      start_file($urandom);
      put_fmt(32'd16, PCM_FORMAT, 16'd2, 32'd44100, 16'd4, PCM_WIDTH);
      put_chunk($urandom, 32'd4);
      send_file();
   endtask

   // random files, mostly well formed
   task automatic test_random_files();
      int unsigned bytes_sent;
      int unsigned pick;
      int unsigned spot;
      bytes_sent = 0;
      while (bytes_sent < 280) begin
         in_idle_enable   = ($urandom_range(0, 3) != 0);
         out_stall_enable = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            build_random_wave();
         end else if (pick < 85) begin
            // one flipped bit anywhere
            build_random_wave();
            spot = $urandom_range(0, file_image.size() - 1);
            file_image[spot] = file_image[spot] ^ (8'd1 << $urandom_range(0, 7));
         end else if (pick < 92) begin
            start_file($urandom);
            put_tag(whp_pkg::TAG_FMT);
            put_le($urandom_range(0, 15), 4);
            put_fill($urandom_range(0, 20));
         end else begin
            file_image.delete();
            if ($urandom_range(0, 1) == 0) put_tag(whp_pkg::TAG_RIFF);
            put_fill($urandom_range(1, 24));
         end
         bytes_sent += file_image.size();
         send_file();
      end
   endtask

   // back-to-back beats with no idling on either side
   task automatic test_steady_stream();
      in_idle_enable   = 1'b0;
      out_stall_enable = 1'b0;
      repeat (4) begin
         build_random_wave();
         send_file();
      end
   endtask

   initial begin
      clear_parse_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_file_tags();
      test_fmt_errors();
      test_format_checks();
      test_chunk_walk();
      test_random_files();
      test_steady_stream();

      req_valid = 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_headers.size() == 0)
         $display("wave_header_parser test passed");
      else
         $display("wave_header_parser test failed");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("wave_header_parser test failed");
      $finish;
   end

endmodule
